// File: hdl/dsrp_pkg.sv
`default_nettype none

package dsrp_pkg;

  // field widths of the channels
  localparam int CMD_W    = 2;
  localparam int HANDLE_W = 6;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;
  localparam int CAP_W    = 7;

  localparam int              POOL_DEPTH_DEF = 64;
  localparam logic [CAP_W-1:0] CAP_RESET     = 7'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_SPAWN       = 2'd0,
    CMD_DESPAWN     = 2'd1,
    CMD_QUERY       = 2'd2,
    CMD_DESPAWN_ALL = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_NOT_ACTIVE = 2'd2,
    ST_OUT_RANGE  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_WR2
  } fsm_t;

endpackage

`default_nettype wire

// File: hdl/dsrp_in_if.sv
`default_nettype none

interface dsrp_in_if;
  logic                             valid;
  logic                             ready;
  dsrp_pkg::cmd_t                   cmd;
  logic [dsrp_pkg::HANDLE_W-1:0]    handle_in;
  logic [dsrp_pkg::POS_W-1:0]       position_in;

  modport source (output valid, cmd, handle_in, position_in, input ready);
  modport sink   (input valid, cmd, handle_in, position_in, output ready);
endinterface

`default_nettype wire

// File: hdl/dsrp_out_if.sv
`default_nettype none

interface dsrp_out_if;
  logic                             valid;
  logic                             ready;
  dsrp_pkg::status_t                status;
  logic [dsrp_pkg::HANDLE_W-1:0]    handle_out;
  logic [dsrp_pkg::COUNT_W-1:0]     active_count;

  modport source (output valid, status, handle_out, active_count, input ready);
  modport sink   (input valid, status, handle_out, active_count, output ready);
endinterface

`default_nettype wire

// File: hdl/dsrp_cfg_if.sv
`default_nettype none

interface dsrp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [dsrp_pkg::CAP_W-1:0]    data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// File: hdl/dsrp_ram.sv
`default_nettype none

module dsrp_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hdl/dense_swap_remove_pool_top.sv
`default_nettype none

// dense handle pool with swap-and-pop removal. active handles sit densely at
// positions 0..count-1 of the order table, and a second table maps each handle
// back to its position; both live in one-port-write RAMs with a registered read.
// per item: spawn, query, despawn-all and a skipped despawn pass through
// IDLE (the accept issues the RAM reads) and EXEC (evaluates and loads the
// result register); a despawn that swaps also goes through WR2, since each table
// needs two writes through its single write port.
// the result register lets the next item in while a result waits; a result
// that is still not taken when the next one is ready holds the block.
// after reset and after every capacity write the block runs a clearing pass
// that restores all POOL_DEPTH entries of both tables to identity; input ready
// is low during the pass, capacity writes are always taken and restart the pass.

module dense_swap_remove_pool_top #(
  parameter int POOL_DEPTH = dsrp_pkg::POOL_DEPTH_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  dsrp_in_if.sink    in_ch,
  dsrp_out_if.source out_ch,
  dsrp_cfg_if.sink   cfg_ch
);

  // table index width, count width, and a common compare width
  localparam int AW = $clog2(POOL_DEPTH);
  localparam int CW = $clog2(POOL_DEPTH + 1);
  localparam int KW = (CW > dsrp_pkg::COUNT_W) ? CW : dsrp_pkg::COUNT_W;

  localparam logic [KW-1:0] DEPTH_K  = KW'(POOL_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(POOL_DEPTH - 1);

  // control state
  dsrp_pkg::fsm_t               state_r, state_nxt;
  logic                         sweep_r, sweep_nxt;
  logic [AW-1:0]                sweep_idx_r, sweep_idx_nxt;
  logic [dsrp_pkg::CAP_W-1:0]   cap_r, cap_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic                         out_valid_r, out_valid_nxt;

  // captured item and swap bookkeeping
  dsrp_pkg::cmd_t               cmd_r, cmd_nxt;
  logic [dsrp_pkg::HANDLE_W-1:0] h_r, h_nxt;
  logic [dsrp_pkg::POS_W-1:0]   p_r, p_nxt;
  logic [AW-1:0]                last_r, last_nxt;

  // result register
  dsrp_pkg::status_t            status_r, status_nxt;
  logic [dsrp_pkg::HANDLE_W-1:0] hout_r, hout_nxt;
  logic [dsrp_pkg::COUNT_W-1:0] acnt_r, acnt_nxt;

  // ram ports
  logic          so_we, hp_we;
  logic [AW-1:0] so_waddr, so_wdata, so_raddr, so_rdata;
  logic [AW-1:0] hp_waddr, hp_wdata, hp_raddr, hp_rdata;

  logic                          in_fire, cfg_fire, go;
  dsrp_pkg::cmd_t                cmd_sel;
  logic [dsrp_pkg::HANDLE_W-1:0] h_sel;
  logic [dsrp_pkg::POS_W-1:0]    p_sel;
  logic [KW-1:0]                 cap_k, count_k, so_k, hp_k, h_k, p_k;
  logic [AW-1:0]                 count_m1;

  // slot_order: position -> handle
  dsrp_ram #(.WIDTH(AW), .DEPTH(POOL_DEPTH)) u_slot_order (
    .clk   (clk),
    .we    (so_we),
    .waddr (so_waddr),
    .wdata (so_wdata),
    .raddr (so_raddr),
    .rdata (so_rdata)
  );

  // handle_position: handle -> position
  dsrp_ram #(.WIDTH(AW), .DEPTH(POOL_DEPTH)) u_handle_pos (
    .clk   (clk),
    .we    (hp_we),
    .waddr (hp_waddr),
    .wdata (hp_wdata),
    .raddr (hp_raddr),
    .rdata (hp_rdata)
  );

  assign in_ch.ready  = (state_r == dsrp_pkg::FSM_IDLE) && !sweep_r;
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_fire     = cfg_ch.valid;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.handle_out   = hout_r;
  assign out_ch.active_count = acnt_r;

  // evaluate only when the result register can take the beat
  assign go = (state_r == dsrp_pkg::FSM_EXEC) && (!out_valid_r || out_ch.ready);

  // effective capacity, clamped to 1..POOL_DEPTH
  always_comb begin
    cap_k = KW'(cap_r);
    if (cap_r == '0) begin
      cap_k = KW'(1);
    end else if (cap_k > DEPTH_K) begin
      cap_k = DEPTH_K;
    end
  end

  assign count_k  = KW'(count_r);
  assign count_m1 = AW'(count_r - CW'(1));
  assign so_k     = KW'(so_rdata);
  assign hp_k     = KW'(hp_rdata);
  assign h_k      = KW'(h_r);
  assign p_k      = KW'(p_r);

  // read addresses come straight from the input beat on accept, then from the
  // captured copy so a stalled evaluation re-reads the same entries
  assign cmd_sel  = (state_r == dsrp_pkg::FSM_IDLE) ? in_ch.cmd : cmd_r;
  assign h_sel    = (state_r == dsrp_pkg::FSM_IDLE) ? in_ch.handle_in : h_r;
  assign p_sel    = (state_r == dsrp_pkg::FSM_IDLE) ? in_ch.position_in : p_r;
  assign hp_raddr = AW'(h_sel);

  always_comb begin
    case (cmd_sel)
      dsrp_pkg::CMD_DESPAWN: so_raddr = count_m1;     // last active handle
      dsrp_pkg::CMD_QUERY:   so_raddr = AW'(p_sel);
      default:               so_raddr = count_r[AW-1:0]; // next free handle
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    sweep_nxt     = sweep_r;
    sweep_idx_nxt = sweep_idx_r;
    cap_nxt       = cap_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    cmd_nxt       = cmd_r;
    h_nxt         = h_r;
    p_nxt         = p_r;
    last_nxt      = last_r;
    status_nxt    = status_r;
    hout_nxt      = hout_r;
    acnt_nxt      = acnt_r;
    so_we         = 1'b0;
    so_waddr      = sweep_idx_r;
    so_wdata      = sweep_idx_r;
    hp_we         = 1'b0;
    hp_waddr      = sweep_idx_r;
    hp_wdata      = sweep_idx_r;

    // result beat leaves
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    // clearing pass: identity into both tables
    if (sweep_r) begin
      so_we         = 1'b1;
      hp_we         = 1'b1;
      sweep_idx_nxt = sweep_idx_r + AW'(1);
      if (sweep_idx_r == LAST_IDX) begin
        sweep_nxt = 1'b0;
      end
    end

    case (state_r)
      dsrp_pkg::FSM_IDLE: begin
        if (in_fire) begin
          cmd_nxt   = in_ch.cmd;
          h_nxt     = in_ch.handle_in;
          p_nxt     = in_ch.position_in;
          state_nxt = dsrp_pkg::FSM_EXEC;
        end
      end
      dsrp_pkg::FSM_EXEC: begin
        if (go) begin
          status_nxt    = dsrp_pkg::ST_OK;
          hout_nxt      = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = dsrp_pkg::FSM_IDLE;
          case (cmd_r)
            dsrp_pkg::CMD_SPAWN: begin
              if (count_k >= cap_k) begin
                status_nxt = dsrp_pkg::ST_FULL;
              end else begin
                hout_nxt  = so_k[dsrp_pkg::HANDLE_W-1:0];
                count_nxt = count_r + CW'(1);
              end
            end
            dsrp_pkg::CMD_DESPAWN: begin
              if ((h_k >= cap_k) || (hp_k >= count_k)) begin
                status_nxt = dsrp_pkg::ST_NOT_ACTIVE;
              end else begin
                count_nxt = count_r - CW'(1);
                // not the last active one: move the last handle into the hole
                if (hp_rdata != count_m1) begin
                  so_we     = 1'b1;
                  so_waddr  = hp_rdata;
                  so_wdata  = so_rdata;
                  hp_we     = 1'b1;
                  hp_waddr  = so_rdata;
                  hp_wdata  = hp_rdata;
                  last_nxt  = count_m1;
                  state_nxt = dsrp_pkg::FSM_WR2;
                end
              end
            end
            dsrp_pkg::CMD_QUERY: begin
              if (p_k >= count_k) begin
                status_nxt = dsrp_pkg::ST_OUT_RANGE;
              end else begin
                hout_nxt = so_k[dsrp_pkg::HANDLE_W-1:0];
              end
            end
            default: begin
              count_nxt = '0;   // despawn all keeps the tables
            end
          endcase
          acnt_nxt = dsrp_pkg::COUNT_W'(count_nxt);
        end
      end
      dsrp_pkg::FSM_WR2: begin
        // second half of the swap: removed handle parks at the old last slot
        so_we     = 1'b1;
        so_waddr  = last_r;
        so_wdata  = AW'(h_r);
        hp_we     = 1'b1;
        hp_waddr  = AW'(h_r);
        hp_wdata  = last_r;
        state_nxt = dsrp_pkg::FSM_IDLE;
      end
      default: begin
        state_nxt = dsrp_pkg::FSM_IDLE;
      end
    endcase

    // capacity write re-creates the pool
    if (cfg_fire) begin
      cap_nxt       = cfg_ch.data;
      count_nxt     = '0;
      sweep_nxt     = 1'b1;
      sweep_idx_nxt = '0;
      state_nxt     = dsrp_pkg::FSM_IDLE;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dsrp_pkg::FSM_IDLE;
      sweep_r     <= 1'b1;
      sweep_idx_r <= '0;
      cap_r       <= dsrp_pkg::CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      sweep_idx_r <= sweep_idx_nxt;
      cap_r       <= cap_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    h_r      <= h_nxt;
    p_r      <= p_nxt;
    last_r   <= last_nxt;
    status_r <= status_nxt;
    hout_r   <= hout_nxt;
    acnt_r   <= acnt_nxt;
  end

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH     = dsrp_pkg::POOL_DEPTH_DEF;
  localparam int GAP_MAX   = 18;
  localparam int SHOW_MAX  = 10;

  // one result beat as the pool should produce it
  typedef struct {
    dsrp_pkg::status_t                status;
    logic [dsrp_pkg::HANDLE_W-1:0]    handle;
    logic [dsrp_pkg::COUNT_W-1:0]     count;
  } pool_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // 10 ns period
  always #5 clk = ~clk;

  dsrp_in_if  in_ch ();
  dsrp_out_if out_ch ();
  dsrp_cfg_if cfg_ch ();

  dense_swap_remove_pool_top #(.POOL_DEPTH(DEPTH)) uut (
    .clk,
    .rst_n,
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // mirror of the pool: order table, handle-to-position table, live count
  logic [dsrp_pkg::HANDLE_W-1:0] slot_tbl  [DEPTH];
  logic [dsrp_pkg::POS_W-1:0]    where_tbl [DEPTH];
  logic [dsrp_pkg::COUNT_W-1:0]  live;
  logic [dsrp_pkg::CAP_W-1:0]    cap_reg;

  // results still owed by the block, oldest first
  pool_result_t pending_results[$];

  // idle control for both sides, changed per phase
  int in_gap_max  = 0;
  int out_gap_max = 0;
  int hold_cycles = 0;

  int mismatches   = 0;
  int items_sent   = 0;
  int cfg_writes   = 0;
  int holds_done   = 0;
  int status_seen [4];

  // capacity register clamped to 1..DEPTH
  function automatic int cap_limit();
    if (cap_reg == 0) return 1;
    if (cap_reg > DEPTH) return DEPTH;
    return int'(cap_reg);
  endfunction

  // pool re-created: both tables back to identity, nothing active
  function automatic void clear_pool();
    for (int i = 0; i < DEPTH; i++) begin
      slot_tbl[i]  = dsrp_pkg::HANDLE_W'(i);
      where_tbl[i] = dsrp_pkg::POS_W'(i);
    end
    live = '0;
  endfunction

  // applies one command to the mirror and returns the beat it must produce
  function automatic pool_result_t pool_apply(dsrp_pkg::cmd_t c,
                                              logic [dsrp_pkg::HANDLE_W-1:0] h,
                                              logic [dsrp_pkg::POS_W-1:0] p);
    pool_result_t r;
    int cap;
    int pos;
    int last;
    logic [dsrp_pkg::HANDLE_W-1:0] other;
    cap      = cap_limit();
    r.status = dsrp_pkg::ST_OK;
    r.handle = '0;
    case (c)
      dsrp_pkg::CMD_SPAWN: begin
        if (live >= cap) begin
          r.status = dsrp_pkg::ST_FULL;
        end else begin
          r.handle = slot_tbl[live];
          live     = live + 1'b1;
        end
      end
      dsrp_pkg::CMD_DESPAWN: begin
        if (h >= cap || where_tbl[h] >= live) begin
          r.status = dsrp_pkg::ST_NOT_ACTIVE;
        end else begin
          pos  = int'(where_tbl[h]);
          last = int'(live) - 1;
          // swap with the last active entry unless it already is the last
          if (pos != last) begin
            other           = slot_tbl[last];
            slot_tbl[pos]   = other;
            slot_tbl[last]  = h;
            where_tbl[other] = dsrp_pkg::POS_W'(pos);
            where_tbl[h]     = dsrp_pkg::POS_W'(last);
          end
          live = live - 1'b1;
        end
      end
      dsrp_pkg::CMD_QUERY: begin
        if (p >= live) r.status = dsrp_pkg::ST_OUT_RANGE;
        else r.handle = slot_tbl[p];
      end
      default: live = '0;
    endcase
    r.count = live;
    return r;
  endfunction

  // zero about half the time, else up to the phase maximum
  function automatic int draw_gap(int max_gap);
    if (max_gap == 0 || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, max_gap);
  endfunction

  task automatic note_failure(string msg);
    mismatches++;
    if (mismatches <= SHOW_MAX) $display("%0t: %s", $realtime, msg);
  endtask

  // offers one beat, waits for the handshake, then predicts its result.
  // valid stays high on return so a back-to-back beat needs no re-raise
  task automatic send_item(dsrp_pkg::cmd_t c, logic [dsrp_pkg::HANDLE_W-1:0] h,
                           logic [dsrp_pkg::POS_W-1:0] p);
    int gap;
    gap = draw_gap(in_gap_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= c;
    in_ch.handle_in   <= h;
    in_ch.position_in <= p;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.insert(pending_results.size(), pool_apply(c, h, p));
    items_sent++;
  endtask

  // stop offering, wait for every owed result plus a few cycles of margin
  task automatic settle();
    int guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (6) @(posedge clk);
  endtask

  // capacity write only while the pool is idle; it re-creates the pool
  task automatic write_capacity(logic [dsrp_pkg::CAP_W-1:0] value);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cap_reg = value;
    clear_pool();
    cfg_writes++;
  endtask

  // random commands biased toward well-formed traffic: despawns mostly of
  // live handles, queries mostly of live positions, a little noise
  task automatic run_random(int count, int spawn_pct, int all_pct);
    int r;
    dsrp_pkg::cmd_t c;
    logic [dsrp_pkg::HANDLE_W-1:0] h;
    logic [dsrp_pkg::POS_W-1:0] p;
    repeat (count) begin
      r = $urandom_range(0, 99);
      h = dsrp_pkg::HANDLE_W'($urandom_range(0, DEPTH - 1));
      p = dsrp_pkg::POS_W'($urandom_range(0, DEPTH - 1));
      if (r < spawn_pct) begin
        c = dsrp_pkg::CMD_SPAWN;
      end else if (r < spawn_pct + 35) begin
        c = dsrp_pkg::CMD_DESPAWN;
        if (live > 0 && $urandom_range(0, 6) != 0)
          h = slot_tbl[$urandom_range(0, int'(live) - 1)];
      end else if (r < 100 - all_pct) begin
        c = dsrp_pkg::CMD_QUERY;
        if (live > 0 && $urandom_range(0, 5) != 0)
          p = dsrp_pkg::POS_W'($urandom_range(0, int'(live) - 1));
      end else begin
        c = dsrp_pkg::CMD_DESPAWN_ALL;
      end
      send_item(c, h, p);
    end
  endtask

  // default capacity straight out of reset, no write yet
  task automatic test_after_reset();
    send_item(dsrp_pkg::CMD_QUERY, '0, '0);         // empty pool, out of range
    send_item(dsrp_pkg::CMD_DESPAWN, '0, '1);       // nothing active yet
    send_item(dsrp_pkg::CMD_DESPAWN_ALL, '1, '1);   // despawn all on empty pool
    send_item(dsrp_pkg::CMD_SPAWN, '1, '0);         // hands out handle 0
    send_item(dsrp_pkg::CMD_QUERY, '1, '0);
    send_item(dsrp_pkg::CMD_QUERY, '0, '1);         // top position, out of range
    send_item(dsrp_pkg::CMD_DESPAWN, '1, '0);       // handle 63 not active
    send_item(dsrp_pkg::CMD_SPAWN, '0, '1);         // handle 1
    send_item(dsrp_pkg::CMD_DESPAWN, 6'd0, '0);     // first of two: swap with last
    send_item(dsrp_pkg::CMD_QUERY, '0, 6'd0);       // now holds handle 1
    send_item(dsrp_pkg::CMD_DESPAWN, 6'd1, '0);     // last active, no swap
    send_item(dsrp_pkg::CMD_DESPAWN_ALL, '0, '0);
  endtask

  // tiny pool: fill to full, swap out the middle, clear
  task automatic test_small_pool();
    write_capacity(dsrp_pkg::CAP_W'(3));
    repeat (3) send_item(dsrp_pkg::CMD_SPAWN, '0, '0);
    send_item(dsrp_pkg::CMD_SPAWN, '1, '1);         // pool full
    send_item(dsrp_pkg::CMD_QUERY, '0, 6'd2);
    send_item(dsrp_pkg::CMD_QUERY, '0, 6'd3);       // beyond the live count
    send_item(dsrp_pkg::CMD_DESPAWN, 6'd1, '0);     // middle handle, swap
    send_item(dsrp_pkg::CMD_QUERY, '0, 6'd1);
    send_item(dsrp_pkg::CMD_DESPAWN, 6'd2, '0);     // now the last one
    send_item(dsrp_pkg::CMD_DESPAWN, 6'd5, '0);     // handle beyond capacity
    send_item(dsrp_pkg::CMD_DESPAWN_ALL, '0, '0);
    send_item(dsrp_pkg::CMD_SPAWN, '0, '0);
  endtask

  // capacity register of zero behaves as one
  task automatic test_zero_capacity();
    write_capacity('0);
    send_item(dsrp_pkg::CMD_SPAWN, '0, '0);
    send_item(dsrp_pkg::CMD_SPAWN, '0, '0);         // already full at one
    send_item(dsrp_pkg::CMD_DESPAWN, 6'd1, '0);
    send_item(dsrp_pkg::CMD_QUERY, '0, 6'd0);
  endtask

  // phases over many capacities, each with its own idle pattern
  task automatic test_random_traffic();
    logic [dsrp_pkg::CAP_W-1:0] caps [12];
    caps = '{7'd127, 7'd64, 7'd1, 7'd2, 7'd65, 7'd5, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0};
    for (int i = 6; i < 12; i++) caps[i] = dsrp_pkg::CAP_W'($urandom_range(1, DEPTH));
    for (int i = 0; i < 12; i++) begin
      write_capacity(caps[i]);
      case (i % 4)
        0: begin in_gap_max = 0;       out_gap_max = 0;       end
        1: begin in_gap_max = GAP_MAX; out_gap_max = GAP_MAX; end
        2: begin in_gap_max = GAP_MAX; out_gap_max = 0;       end
        default: begin in_gap_max = 0; out_gap_max = GAP_MAX; end
      endcase
      // early phases lean on spawn with no clears so the big pools fill up
      if (i < 2) run_random(140, 60, 0);
      else run_random(140, $urandom_range(35, 60), $urandom_range(0, 3));
    end
  endtask

  // receiver holds off for long stretches while items keep coming
  task automatic test_backpressure();
    write_capacity(dsrp_pkg::CAP_W'(16));
    in_gap_max  = 0;
    out_gap_max = 0;
    hold_cycles = 250;
    run_random(50, 55, 1);
    hold_cycles = 180;
    run_random(50, 45, 1);
    in_gap_max  = GAP_MAX;
    out_gap_max = GAP_MAX;
  endtask

  // result side: ready with random stalls, or one long hold when asked
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_cycles > 0) begin
        gap         = hold_cycles;
        hold_cycles = 0;
        holds_done++;
      end else begin
        gap = draw_gap(out_gap_max);
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // every accepted result beat against the oldest owed result
  always @(posedge clk) begin
    pool_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      status_seen[out_ch.status]++;
      if (pending_results.size() == 0) begin
        note_failure($sformatf("result with nothing owed: status %0d handle %0d count %0d",
                               out_ch.status, out_ch.handle_out, out_ch.active_count));
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status || out_ch.handle_out !== want.handle ||
            out_ch.active_count !== want.count)
          note_failure($sformatf(
            "mismatch: status exp %0d got %0d, handle exp %0d got %0d, count exp %0d got %0d",
            want.status, out_ch.status, want.handle, out_ch.handle_out,
            want.count, out_ch.active_count));
      end
    end
  end

  // hard limit on the whole run
  initial begin
    #5_000_000;
    $display("FAIL dense_swap_remove_pool_top");
    $finish;
  end

  initial begin
    // all inputs known from time zero
    in_ch.valid       <= 1'b0;
    in_ch.cmd         <= dsrp_pkg::CMD_SPAWN;
    in_ch.handle_in   <= '0;
    in_ch.position_in <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.data       <= dsrp_pkg::CAP_RESET;
    cap_reg = dsrp_pkg::CAP_RESET;
    clear_pool();
    foreach (status_seen[i]) status_seen[i] = 0;

    // synchronous reset
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    in_gap_max  = GAP_MAX;
    out_gap_max = GAP_MAX;
    test_after_reset();
    test_small_pool();
    test_zero_capacity();
    test_backpressure();
    test_random_traffic();

    settle();
    if (pending_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", pending_results.size()));

    $display("covered %0d commands across %0d capacity writes, %0d long receiver holds",
             items_sent, cfg_writes, holds_done);
    $display("results by status: ok %0d, full %0d, not active %0d, out of range %0d",
             status_seen[dsrp_pkg::ST_OK], status_seen[dsrp_pkg::ST_FULL],
             status_seen[dsrp_pkg::ST_NOT_ACTIVE], status_seen[dsrp_pkg::ST_OUT_RANGE]);
    if (mismatches == 0) begin
      $display("PASS dense_swap_remove_pool_top");
    end else begin
      $display("FAIL dense_swap_remove_pool_top");
    end
    $finish;
  end

endmodule

`default_nettype wire
